### rtl/core/assert_macros.svh
// Assertion macros shared by the window alarm RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that an antecedent is followed in the next cycle by a consequent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/twa_pkg.sv
// Types and codes shared by the window alarm modules.
`timescale 1ns / 1ps
package twa_pkg;

   // command codes carried in the request
   localparam logic [1:0] CMD_SAMPLE = 2'd0;
   localparam logic [1:0] CMD_TICK   = 2'd1;
   localparam logic [1:0] CMD_LIMIT  = 2'd2;

   // channel status codes
   localparam logic [1:0] ST_UNKNOWN = 2'd0;
   localparam logic [1:0] ST_OUT     = 2'd1;
   localparam logic [1:0] ST_IN      = 2'd2;

   // event codes
   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_RAISED  = 2'd1;
   localparam logic [1:0] EV_CLEARED = 2'd2;
   localparam logic [1:0] EV_REJECT  = 2'd3;

   // register indexes (word address)
   localparam logic [1:0] REG_CHANNEL_COUNT = 2'd0;
   localparam logic [1:0] REG_CLAMP_HIGH    = 2'd1;
   localparam logic [1:0] REG_CLAMP_LOW     = 2'd2;

   localparam logic [4:0]         RESET_CHANNEL_COUNT = 5'd16;
   localparam logic signed [15:0] RESET_CLAMP_HIGH    = 16'sd999;
   localparam logic signed [15:0] RESET_CLAMP_LOW     = -16'sd999;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [3:0]         channel;
      logic signed [15:0] temperature;
      logic signed [15:0] upper_in;
      logic signed [15:0] lower_in;
   } req_type;

   typedef struct packed {
      logic [3:0]         out_channel;
      logic [1:0]         status;
      logic [1:0]         event_res;
      logic [15:0]        age_before;
      logic signed [15:0] upper_out;
      logic signed [15:0] lower_out;
   } rsp_type;

   typedef struct packed {
      logic [4:0]         channel_count;
      logic signed [15:0] clamp_high;
      logic signed [15:0] clamp_low;
   } cfg_type;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } ctrl_state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic slot_free;
   } dp_status_type;

endpackage

### rtl/core/twa_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
module twa_csr import twa_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_CHANNEL_COUNT: cfg_in.channel_count = pwdata[4:0];
            REG_CLAMP_HIGH:    cfg_in.clamp_high    = pwdata[15:0];
            REG_CLAMP_LOW:     cfg_in.clamp_low     = pwdata[15:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CHANNEL_COUNT: prdata = {27'd0, cfg_ff.channel_count};
         REG_CLAMP_HIGH:    prdata = {{16{cfg_ff.clamp_high[15]}}, cfg_ff.clamp_high};
         REG_CLAMP_LOW:     prdata = {{16{cfg_ff.clamp_low[15]}}, cfg_ff.clamp_low};
         default:           prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.channel_count <= RESET_CHANNEL_COUNT;
         cfg_ff.clamp_high    <= RESET_CLAMP_HIGH;
         cfg_ff.clamp_low     <= RESET_CLAMP_LOW;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/core/twa_ctrl.sv
// Controller: capture a request, then execute it once the output slot is free.
`timescale 1ns / 1ps
module twa_ctrl import twa_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type dp_status,
   output dp_cmd_type    dp_cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (dp_status.slot_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      dp_cmd.load = 1'b0;
      dp_cmd.exec = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            dp_cmd.load = req_valid;
         end
         S_EXEC: begin
            dp_cmd.exec = dp_status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/core/twa_dpath.sv
// Datapath: per-channel limits, status and age, and the result register.
`timescale 1ns / 1ps
module twa_dpath import twa_pkg::*; #(
   parameter int CHANNELS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  cfg_type       cfg,
   input  dp_cmd_type    dp_cmd,
   output dp_status_type dp_status,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output rsp_type       rsp_data
);

   // only channels 0..15 can be named by a request
   localparam int STORED = (CHANNELS < 16) ? CHANNELS : 16;
   localparam int IW     = (STORED > 1) ? $clog2(STORED) : 1;
   localparam int CW     = ($clog2(CHANNELS + 1) > 5) ? $clog2(CHANNELS + 1) : 5;

   req_type            req_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   logic signed [15:0] hi_lim_ff [STORED];
   logic signed [15:0] lo_lim_ff [STORED];
   logic [1:0]         status_ff [STORED];
   logic [1:0]         status_in [STORED];
   logic [15:0]        age_ff    [STORED];
   logic [15:0]        age_in    [STORED];

   logic [IW-1:0]      idx;
   logic [CW-1:0]      ch_wide;
   logic [CW-1:0]      count_wide;
   logic [CW-1:0]      active;
   logic               ch_exists;
   logic               lim_wr;
   logic signed [15:0] clamp_up;
   logic signed [15:0] clamp_lo;
   logic signed [15:0] new_up;
   logic signed [15:0] new_lo;
   logic               in_window;

   function automatic logic signed [15:0] clamp_limit(input logic signed [15:0] v,
                                                      input logic signed [15:0] hi,
                                                      input logic signed [15:0] lo);
      logic signed [15:0] r;
      r = (v > hi) ? hi : v;
      r = (r < lo) ? lo : r;
      return r;
   endfunction

   assign idx        = req_ff.channel[IW-1:0];
   assign ch_wide    = CW'(req_ff.channel);
   assign count_wide = CW'(cfg.channel_count);
   assign active     = (count_wide > CW'(CHANNELS)) ? CW'(CHANNELS) : count_wide;
   assign ch_exists  = ch_wide < CW'(CHANNELS);

   assign clamp_up  = clamp_limit(req_ff.upper_in, cfg.clamp_high, cfg.clamp_low);
   assign clamp_lo  = clamp_limit(req_ff.lower_in, cfg.clamp_high, cfg.clamp_low);
   assign new_up    = (clamp_lo > clamp_up) ? clamp_lo : clamp_up;
   assign new_lo    = (clamp_lo > clamp_up) ? clamp_up : clamp_lo;
   assign in_window = (req_ff.temperature >= lo_lim_ff[idx]) &&
                      (req_ff.temperature <= hi_lim_ff[idx]);

   assign dp_status.slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_data            = rsp_ff;

   always_comb begin
      rsp_in    = '0;
      lim_wr    = 1'b0;
      status_in = status_ff;
      age_in    = age_ff;
      case (req_ff.cmd)
         CMD_TICK: begin
            for (int i = 0; i < STORED; i++) begin
               if (CW'(i) < active && age_ff[i] != 16'hFFFF) age_in[i] = age_ff[i] + 16'd1;
            end
         end
         CMD_SAMPLE: begin
            rsp_in.out_channel = req_ff.channel;
            if (!ch_exists || ch_wide >= active) begin
               rsp_in.event_res = EV_REJECT;
            end else begin
               rsp_in.age_before = age_ff[idx];
               rsp_in.upper_out  = hi_lim_ff[idx];
               rsp_in.lower_out  = lo_lim_ff[idx];
               if (in_window) begin
                  rsp_in.status    = ST_IN;
                  rsp_in.event_res = (status_ff[idx] == ST_OUT) ? EV_CLEARED : EV_NONE;
               end else begin
                  rsp_in.status    = ST_OUT;
                  rsp_in.event_res = (status_ff[idx] != ST_OUT) ? EV_RAISED : EV_NONE;
               end
               status_in[idx] = rsp_in.status;
               age_in[idx]    = 16'd0;
            end
         end
         CMD_LIMIT: begin
            rsp_in.out_channel = req_ff.channel;
            if (!ch_exists) begin
               rsp_in.event_res = EV_REJECT;
            end else begin
               lim_wr            = 1'b1;
               rsp_in.status     = status_ff[idx];
               rsp_in.age_before = age_ff[idx];
               rsp_in.upper_out  = new_up;
               rsp_in.lower_out  = new_lo;
            end
         end
         default: rsp_in = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.exec) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < STORED; i++) begin
            status_ff[i] <= ST_UNKNOWN;
            age_ff[i]    <= 16'd0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (dp_cmd.exec) begin
            status_ff <= status_in;
            age_ff    <= age_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.load) req_ff <= req_data;
      if (dp_cmd.exec) rsp_ff <= rsp_in;
      if (dp_cmd.exec && lim_wr) begin
         hi_lim_ff[idx] <= new_up;
         lo_lim_ff[idx] <= new_lo;
      end
   end

endmodule

### rtl/core/multichannel_temp_window_alarm_core.sv
// Top level of the multichannel temperature window alarm.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Per-channel temperature window alarm. Each request is a sample, a
// one-second tick or a limit write, and every request yields exactly one
// response. An item has two steps: one captures the request transfer,
// one does a read-modify-write of the channel's limit, status and age
// registers and loads the output register. The execute step waits while
// the output register still holds an untaken response, and no new request
// is taken until the execute step of the last one is done. A new request is
// taken while a finished response waits. Status and age registers are
// cleared by reset; limits are not, and must be written before a channel's
// first sample. Configuration writes land at byte addresses 0, 4 and 8
// (channel count, clamp high, clamp low) and should only be issued while
// the block is idle.
module multichannel_temp_window_alarm_core import twa_pkg::*; #(
   parameter int CHANNELS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type       cfg;
   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   // configuration registers
   twa_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequence capture and execute
   twa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   // hold channel state and drive the response register
   twa_dpath #(
      .CHANNELS (CHANNELS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cfg       (cfg),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   // a captured request is always followed by an execute cycle
   `ASSERT_NEXT(a_exec_after_accept, clock, reset, req_valid && req_ready, !req_ready, "request accepted twice in a row")
   // a rejected channel reports no state
   `ASSERT_HOLDS(a_reject_clean, clock, reset, !(rsp_valid && rsp_data.event_res == EV_REJECT) || (rsp_data.status == ST_UNKNOWN && rsp_data.age_before == 16'd0), "rejected response carries state")
   // a raised alarm always leaves the channel out of range
   `ASSERT_HOLDS(a_raised_out, clock, reset, !(rsp_valid && rsp_data.event_res == EV_RAISED) || rsp_data.status == ST_OUT, "alarm raised without out-of-range status")
   // a cleared alarm always leaves the channel in range
   `ASSERT_HOLDS(a_cleared_in, clock, reset, !(rsp_valid && rsp_data.event_res == EV_CLEARED) || rsp_data.status == ST_IN, "alarm cleared without in-range status")

endmodule
